// ===== src/ddodo_pkg.sv =====
// Shared widths, register codes, reset values, CORDIC table and saturation helpers.
`default_nettype none

package ddodo_pkg;

    localparam int unsigned REV_TICKS_DEF    = 4096;
    localparam int unsigned CORDIC_STEPS_DEF = 24;

    localparam int POS_W      = 32;
    localparam int POSE_W     = 48;
    localparam int ANG_W      = 32;
    localparam int QUAT_W     = 32;
    localparam int RATE_W     = 10;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MAG_W      = 48;
    localparam int ACC_W      = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_TICK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_PER_TICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_RATE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RIGHT    = 2'd3;

    localparam logic [31:0]       RST_DIST_PER_TICK    = 32'd217418;
    localparam logic [31:0]       RST_HEADING_PER_TICK = 32'd55364813;
    localparam logic [RATE_W-1:0] RST_UPDATE_RATE      = 10'd10;
    localparam logic              RST_REVERSE_RIGHT    = 1'b1;

    localparam logic [POSE_W-1:0] POSE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [POSE_W-1:0] POSE_MIN = 48'h8000_0000_0000;
    localparam logic [ACC_W-1:0]  SAT_POS  = ACC_W'(POSE_MAX);
    localparam logic [ACC_W-1:0]  SAT_NEG  = ACC_W'(POSE_MIN);

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE   = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

    // atan(2^-i), full turn = 2^32
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [3:0] {
        OP_DIST,
        OP_DTH,
        OP_X_HI,
        OP_X_LO,
        OP_Y_HI,
        OP_Y_LO,
        OP_LV_HI,
        OP_LV_LO,
        OP_AV_HI,
        OP_AV_LO
    } t_op;

    // magnitude clamped so that the signed result fits in 48 bits
    function automatic logic [MAG_W-1:0] f_sat_mag(input logic [ACC_W-1:0] mag, input logic neg);
        logic [ACC_W-1:0] lim;
        lim = neg ? SAT_NEG : SAT_POS;
        return (mag > lim) ? lim[MAG_W-1:0] : mag[MAG_W-1:0];
    endfunction

    function automatic logic [POSE_W-1:0] f_with_sign(input logic [MAG_W-1:0] mag,
                                                      input logic neg);
        return neg ? POSE_W'(-mag) : mag;
    endfunction

    // acc +/- mag, clamped to the 48-bit signed range
    function automatic logic [POSE_W-1:0] f_acc_add(input logic [POSE_W-1:0] acc,
                                                    input logic [MAG_W-1:0] mag,
                                                    input logic neg);
        logic [POSE_W:0] s;
        s = neg ? ({acc[POSE_W-1], acc} - {1'b0, mag}) : ({acc[POSE_W-1], acc} + {1'b0, mag});
        if (s[POSE_W] != s[POSE_W-1]) begin
            return s[POSE_W] ? POSE_MIN : POSE_MAX;
        end
        return s[POSE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/diff_drive_odometry_unit.sv =====
// Differential-drive wheel odometry: encoder deltas to pose, quaternion and velocities.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_left_position, i_right_position
//  out     | output    | o_out_valid / i_out_stall  | pose, heading, quat z/w, velocities
//  cfg     | input     | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// Each transaction makes two passes of the shared CORDIC shift-add stage and ten passes of the
// single multiplier; no new input is accepted until the transaction is through.
// Synchronous active-low reset clears pose, heading, last positions and the registers' defaults.
// The result sits in an output register, so a stalled output only holds the block in its final
// state; a new input is taken as soon as that result is parked.
`default_nettype none

module diff_drive_odometry_unit #(
    parameter int unsigned REV_TICKS    = ddodo_pkg::REV_TICKS_DEF,
    parameter int unsigned CORDIC_STEPS = ddodo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [ddodo_pkg::POS_W-1:0]      i_left_position,
    input  logic signed [ddodo_pkg::POS_W-1:0]      i_right_position,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ddodo_pkg::POSE_W-1:0]     o_pos_x,
    output logic signed [ddodo_pkg::POSE_W-1:0]     o_pos_y,
    output logic        [ddodo_pkg::ANG_W-1:0]      o_heading,
    output logic signed [ddodo_pkg::QUAT_W-1:0]     o_quat_z,
    output logic signed [ddodo_pkg::QUAT_W-1:0]     o_quat_w,
    output logic signed [ddodo_pkg::POSE_W-1:0]     o_lin_vel,
    output logic signed [ddodo_pkg::POSE_W-1:0]     o_ang_vel,
    input  logic                                    i_cfg_wr_en,
    input  logic        [ddodo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [ddodo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddodo_pkg::*;

    localparam logic signed [31:0] REV_HALF  = 32'(REV_TICKS / 2);
    localparam logic signed [31:0] REV_FULL  = 32'(REV_TICKS);
    localparam logic [4:0]         LAST_ITER = 5'(CORDIC_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREP   = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_ACC    = 9'b000001000,
        S_APPLY  = 9'b000010000,
        S_CINIT  = 9'b000100000,
        S_CORDIC = 9'b001000000,
        S_CPOST  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    function automatic logic signed [31:0] f_fold(input logic [31:0] cur, input logic [31:0] prev);
        logic signed [31:0] d;
        d = $signed(cur - prev);
        if (d > REV_HALF) begin
            d = d - REV_FULL;
        end else if (d < -REV_HALF) begin
            d = d + REV_FULL;
        end
        return d;
    endfunction

    // control and architectural state
    t_state              r_state, n_state;
    t_op                 r_op;
    logic                r_pass2;
    logic [4:0]          r_iter;
    logic                r_out_valid;
    logic [31:0]         r_dpt;
    logic [31:0]         r_hpt;
    logic [RATE_W-1:0]   r_rate;
    logic                r_rev;
    logic [POS_W-1:0]    r_last_left;
    logic [POS_W-1:0]    r_last_right;
    logic [ANG_W-1:0]    r_heading;
    logic [POSE_W-1:0]   r_x;
    logic [POSE_W-1:0]   r_y;

    // datapath
    logic signed [31:0]  r_dl, r_dr;
    logic [32:0]         r_sum_mag, r_dif_mag;
    logic                r_sum_neg, r_dif_neg;
    logic [MAG_W-1:0]    r_dist_mag, r_dth_mag;
    logic                r_dist_neg, r_dth_neg;
    logic [64:0]         r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic signed [33:0]  r_cx, r_cy, r_cz;
    logic                r_flip;
    logic [30:0]         r_c_mag, r_s_mag;
    logic                r_c_neg, r_s_neg;
    logic [POSE_W-1:0]   r_lv, r_av;

    // output register
    logic [POSE_W-1:0]   r_o_x, r_o_y, r_o_lv, r_o_av;
    logic [ANG_W-1:0]    r_o_heading;
    logic [QUAT_W-1:0]   r_o_qz, r_o_qw;

    logic                in_fire;
    logic                load_out;
    logic signed [32:0]  dr_adj;
    logic signed [33:0]  sum34, dif34;
    logic [32:0]         mul_a;
    logic [31:0]         mul_b;
    logic [64:0]         mul_prod;
    logic [MAG_W-1:0]    dist_sat, dth_sat;
    logic [ANG_W-1:0]    heading_step;
    logic                x_neg, y_neg;
    logic [ANG_W-1:0]    cordic_ang;
    logic signed [33:0]  z0;
    logic signed [33:0]  sh_x, sh_y, atan_v;
    logic signed [33:0]  x_abs, y_abs;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // sum and difference of the wheel deltas
    always_comb begin
        dr_adj = r_rev ? -33'(r_dr) : 33'(r_dr);
        sum34  = 34'(r_dl) + 34'(dr_adj);
        dif34  = 34'(dr_adj) - 34'(r_dl);
    end

    // shared multiplier operand select
    always_comb begin
        case (r_op)
            OP_DIST: begin
                mul_a = r_sum_mag;
                mul_b = r_dpt;
            end
            OP_DTH: begin
                mul_a = r_dif_mag;
                mul_b = r_hpt;
            end
            OP_X_HI: begin
                mul_a = 33'(r_dist_mag[47:24]);
                mul_b = 32'(r_c_mag);
            end
            OP_X_LO: begin
                mul_a = 33'(r_dist_mag[23:0]);
                mul_b = 32'(r_c_mag);
            end
            OP_Y_HI: begin
                mul_a = 33'(r_dist_mag[47:24]);
                mul_b = 32'(r_s_mag);
            end
            OP_Y_LO: begin
                mul_a = 33'(r_dist_mag[23:0]);
                mul_b = 32'(r_s_mag);
            end
            OP_LV_HI: begin
                mul_a = 33'(r_dist_mag[47:24]);
                mul_b = 32'(r_rate);
            end
            OP_LV_LO: begin
                mul_a = 33'(r_dist_mag[23:0]);
                mul_b = 32'(r_rate);
            end
            OP_AV_HI: begin
                mul_a = 33'(r_dth_mag[47:24]);
                mul_b = 32'(r_rate);
            end
            OP_AV_LO: begin
                mul_a = 33'(r_dth_mag[23:0]);
                mul_b = 32'(r_rate);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_prod = 65'(mul_a) * 65'(mul_b);
    end

    always_comb begin
        dist_sat     = f_sat_mag(ACC_W'(r_prod >> 1), r_sum_neg);
        dth_sat      = f_sat_mag(ACC_W'(r_prod >> 8), r_dif_neg);
        // heading takes the low 32 bits of the signed step
        heading_step = r_dif_neg ? (r_heading - dth_sat[31:0]) : (r_heading + dth_sat[31:0]);
        x_neg        = r_dist_neg ^ r_c_neg;
        y_neg        = r_dist_neg ^ r_s_neg;
    end

    // CORDIC: input angle (heading, halved on the second pass), shift-add step, magnitude of the result
    always_comb begin
        cordic_ang = r_pass2 ? {1'b0, r_heading[ANG_W-1:1]} : r_heading;
        z0         = 34'($signed(cordic_ang));
        sh_x       = r_cx >>> r_iter;
        sh_y       = r_cy >>> r_iter;
        atan_v     = $signed(34'(ATAN_TAB[r_iter]));
        x_abs      = r_cx[33] ? -r_cx : r_cx;
        y_abs      = r_cy[33] ? -r_cy : r_cy;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:   n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC: begin
                case (r_op)
                    OP_DTH:                              n_state = S_CINIT;
                    OP_X_LO, OP_Y_LO, OP_LV_LO, OP_AV_LO: n_state = S_APPLY;
                    default:                             n_state = S_MUL;
                endcase
            end
            S_APPLY: begin
                n_state = (r_op == OP_AV_LO) ? S_CINIT : S_MUL;
            end
            S_CINIT:  n_state = S_CORDIC;
            S_CORDIC: begin
                if (r_iter == LAST_ITER) begin
                    n_state = S_CPOST;
                end
            end
            S_CPOST: begin
                n_state = r_pass2 ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control, configuration and the odometry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_DIST;
            r_pass2      <= 1'b0;
            r_iter       <= '0;
            r_out_valid  <= 1'b0;
            r_dpt        <= RST_DIST_PER_TICK;
            r_hpt        <= RST_HEADING_PER_TICK;
            r_rate       <= RST_UPDATE_RATE;
            r_rev        <= RST_REVERSE_RIGHT;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_heading    <= '0;
            r_x          <= '0;
            r_y          <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DIST_PER_TICK:    r_dpt  <= i_cfg_data;
                    CFG_HEADING_PER_TICK: r_hpt  <= i_cfg_data;
                    CFG_UPDATE_RATE:      r_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_REVERSE_RIGHT:    r_rev  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_last_left  <= i_left_position;
                        r_last_right <= i_right_position;
                    end
                end
                S_PREP: r_op <= OP_DIST;
                S_ACC: begin
                    case (r_op)
                        OP_DIST:  r_op <= OP_DTH;
                        OP_DTH: begin
                            r_heading <= heading_step;
                            r_pass2   <= 1'b0;
                        end
                        OP_X_HI:  r_op <= OP_X_LO;
                        OP_Y_HI:  r_op <= OP_Y_LO;
                        OP_LV_HI: r_op <= OP_LV_LO;
                        OP_AV_HI: r_op <= OP_AV_LO;
                        default: ;
                    endcase
                end
                S_APPLY: begin
                    case (r_op)
                        OP_X_LO: begin
                            r_x  <= f_acc_add(r_x, f_sat_mag(r_acc >> 30, x_neg), x_neg);
                            r_op <= OP_Y_HI;
                        end
                        OP_Y_LO: begin
                            r_y  <= f_acc_add(r_y, f_sat_mag(r_acc >> 30, y_neg), y_neg);
                            r_op <= OP_LV_HI;
                        end
                        OP_LV_LO: r_op <= OP_AV_HI;
                        OP_AV_LO: r_pass2 <= 1'b1;
                        default: ;
                    endcase
                end
                S_CINIT:  r_iter <= '0;
                S_CORDIC: r_iter <= r_iter + 5'd1;
                S_CPOST: begin
                    if (!r_pass2) begin
                        r_op <= OP_X_HI;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_dl <= f_fold(i_left_position, r_last_left);
                    r_dr <= f_fold(i_right_position, r_last_right);
                end
            end
            S_PREP: begin
                r_sum_mag <= sum34[33] ? 33'(-sum34) : 33'(sum34);
                r_sum_neg <= sum34[33];
                r_dif_mag <= dif34[33] ? 33'(-dif34) : 33'(dif34);
                r_dif_neg <= dif34[33];
            end
            S_MUL: r_prod <= mul_prod;
            S_ACC: begin
                case (r_op)
                    OP_DIST: begin
                        r_dist_mag <= dist_sat;
                        r_dist_neg <= r_sum_neg;
                    end
                    OP_DTH: begin
                        r_dth_mag <= dth_sat;
                        r_dth_neg <= r_dif_neg;
                    end
                    OP_X_HI, OP_Y_HI, OP_LV_HI, OP_AV_HI: r_acc <= ACC_W'(r_prod) << 24;
                    default: r_acc <= r_acc + ACC_W'(r_prod);
                endcase
            end
            S_APPLY: begin
                case (r_op)
                    OP_LV_LO: r_lv <= f_with_sign(f_sat_mag(r_acc, r_dist_neg), r_dist_neg);
                    OP_AV_LO: r_av <= f_with_sign(f_sat_mag(r_acc, r_dth_neg), r_dth_neg);
                    default: ;
                endcase
            end
            S_CINIT: begin
                r_cx <= CORDIC_X0;
                r_cy <= '0;
                // fold into [-pi/2, pi/2], negate at the end
                if (z0 > Q30_ONE) begin
                    r_cz   <= z0 - HALF_TURN;
                    r_flip <= 1'b1;
                end else if (z0 < -Q30_ONE) begin
                    r_cz   <= z0 + HALF_TURN;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= z0;
                    r_flip <= 1'b0;
                end
            end
            S_CORDIC: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_cz <= r_cz + atan_v;
                end
            end
            S_CPOST: begin
                r_c_mag <= (x_abs > Q30_ONE) ? 31'(Q30_ONE) : x_abs[30:0];
                r_s_mag <= (y_abs > Q30_ONE) ? 31'(Q30_ONE) : y_abs[30:0];
                r_c_neg <= r_cx[33] ^ r_flip;
                r_s_neg <= r_cy[33] ^ r_flip;
            end
            S_DONE: begin
                if (load_out) begin
                    r_o_x       <= r_x;
                    r_o_y       <= r_y;
                    r_o_heading <= r_heading;
                    r_o_qz      <= r_s_neg ? -QUAT_W'(r_s_mag) : QUAT_W'(r_s_mag);
                    r_o_qw      <= r_c_neg ? -QUAT_W'(r_c_mag) : QUAT_W'(r_c_mag);
                    r_o_lv      <= r_lv;
                    r_o_av      <= r_av;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_o_x;
    assign o_pos_y     = r_o_y;
    assign o_heading   = r_o_heading;
    assign o_quat_z    = r_o_qz;
    assign o_quat_w    = r_o_qw;
    assign o_lin_vel   = r_o_lv;
    assign o_ang_vel   = r_o_av;

endmodule

`default_nettype wire

// ===== src/ddodo_checker.sv =====
// Port-level checks for the odometry unit, bound to the top level.
`default_nettype none

module ddodo_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    o_in_stall,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [ddodo_pkg::POSE_W-1:0]     o_pos_x,
    input  logic signed [ddodo_pkg::POSE_W-1:0]     o_pos_y,
    input  logic        [ddodo_pkg::ANG_W-1:0]      o_heading,
    input  logic signed [ddodo_pkg::QUAT_W-1:0]     o_quat_z,
    input  logic signed [ddodo_pkg::QUAT_W-1:0]     o_quat_w
);
    import ddodo_pkg::*;

    localparam logic signed [QUAT_W-1:0] QMAX = 32'sd1073741824;
    localparam logic signed [QUAT_W-1:0] QMIN = -32'sd1073741824;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_heading) && $stable(o_quat_z) && $stable(o_quat_w))
        else $error("output changed while stalled");

    // an accepted transaction keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    // results only appear at the end of the work on a transaction
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without preceding work");

    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quat_z <= QMAX) && (o_quat_z >= QMIN)
            && (o_quat_w <= QMAX) && (o_quat_w >= QMIN))
        else $error("quaternion component out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind diff_drive_odometry_unit ddodo_checker u_ddodo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_pos_y     (o_pos_y),
    .o_heading   (o_heading),
    .o_quat_z    (o_quat_z),
    .o_quat_w    (o_quat_w)
);

`default_nettype wire
